// ----- sv/vdhp_pkg.sv -----
// Package of shared types and constants for the voice datagram header parser.
package vdhp_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_TOO_WIDE  = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;
    localparam logic [2:0] ST_BAD_COUNT = 3'd5;

    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_SENDER = 3'd1;
    localparam logic [2:0] PH_SEQ    = 3'd2;
    localparam logic [2:0] PH_LEN    = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_DRAIN  = 3'd5;

    localparam logic [0:0] CFG_HAS_SENDER = 1'd0;
    localparam logic [0:0] CFG_MAX_TYPE   = 1'd1;

    localparam logic [7:0]  PFX_INVERT = 8'hf8;
    localparam logic [13:0] POS_BYTES  = 14'd12;
    localparam logic [13:0] COUNT_MAX  = 14'h3fff;

    // One result item as it travels from the parser to the output queue.
    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [2:0]  status;
        logic [2:0]  pkt_type;
        logic [4:0]  target;
        logic [31:0] sender_session;
        logic [63:0] frame_sequence;
        logic [12:0] payload_length;
        logic        terminator;
        logic        has_position;
    } t_result;

endpackage

// ----- sv/vdhp_front.sv -----
// Front part: parses each accepted byte and forms at most one result item.
module vdhp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_has_sender,
    input  logic [2:0]       i_max_type,
    output logic             o_emit,
    output vdhp_pkg::t_result o_res
);

    logic [2:0]  r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_left, n_left;
    logic        r_inv, n_inv;
    logic [2:0]  r_type, n_type;
    logic [4:0]  r_target, n_target;
    logic [31:0] r_sender, n_sender;
    logic [63:0] r_seq, n_seq;
    logic [12:0] r_len, n_len;
    logic        r_term, n_term;
    logic [13:0] r_count, n_count;
    logic [2:0]  r_err, n_err;

    // Next-state logic for one byte.
    always_comb begin
        logic        val_ok;
        logic [63:0] v;
        logic        pay;
        logic [2:0]  st;
        logic        pos;
        n_phase = r_phase; n_acc = r_acc; n_left = r_left; n_inv = r_inv;
        n_type = r_type; n_target = r_target; n_sender = r_sender; n_seq = r_seq;
        n_len = r_len; n_term = r_term; n_count = r_count; n_err = r_err;
        val_ok = 1'b0; v = '0; pay = 1'b0; st = vdhp_pkg::ST_OK; pos = 1'b0;
        unique case (r_phase) inside
            vdhp_pkg::PH_FIRST: begin
                n_type = i_byte[7:5];
                n_target = i_byte[4:0];
                if (i_byte[7:5] > i_max_type) begin
                    n_err = vdhp_pkg::ST_BAD_TYPE;
                    n_phase = vdhp_pkg::PH_DRAIN;
                end else begin
                    n_phase = i_has_sender ? vdhp_pkg::PH_SENDER : vdhp_pkg::PH_SEQ;
                end
            end
            vdhp_pkg::PH_SENDER, vdhp_pkg::PH_SEQ, vdhp_pkg::PH_LEN: begin
                if (r_left != 4'd0) begin
                    n_acc = {r_acc[55:0], i_byte};
                    n_left = r_left - 4'd1;
                    if (r_left == 4'd1) begin
                        val_ok = 1'b1;
                        v = {r_acc[55:0], i_byte};
                    end
                end else if (!i_byte[7]) begin
                    val_ok = 1'b1; v = {57'd0, i_byte[6:0]};
                end else if (i_byte[7:6] == 2'b10) begin
                    n_acc = {58'd0, i_byte[5:0]}; n_left = 4'd1;
                end else if (i_byte[7:5] == 3'b110) begin
                    n_acc = {59'd0, i_byte[4:0]}; n_left = 4'd2;
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_acc = {60'd0, i_byte[3:0]}; n_left = 4'd3;
                end else if (i_byte[3:2] == 2'b00) begin
                    n_acc = '0; n_left = 4'd4;
                end else if (i_byte[3:2] == 2'b01) begin
                    n_acc = '0; n_left = 4'd8;
                end else if ((i_byte & 8'hfc) == vdhp_pkg::PFX_INVERT) begin
                    n_inv = ~r_inv;
                end else begin
                    val_ok = 1'b1; v = ~{62'd0, i_byte[1:0]};
                end
                if (val_ok) begin
                    if (r_inv) v = ~v;
                    n_inv = 1'b0; n_acc = '0; n_left = 4'd0;
                    if (r_phase == vdhp_pkg::PH_SENDER) begin
                        if (v[63:32] != 32'd0) begin
                            n_err = vdhp_pkg::ST_TOO_WIDE; n_phase = vdhp_pkg::PH_DRAIN;
                        end else begin
                            n_sender = v[31:0]; n_phase = vdhp_pkg::PH_SEQ;
                        end
                    end else if (r_phase == vdhp_pkg::PH_SEQ) begin
                        n_seq = v; n_phase = vdhp_pkg::PH_LEN;
                    end else if (v[63:16] != 48'd0) begin
                        n_err = vdhp_pkg::ST_TOO_WIDE; n_phase = vdhp_pkg::PH_DRAIN;
                    end else begin
                        n_len = v[12:0]; n_term = v[13]; n_count = '0;
                        n_phase = vdhp_pkg::PH_BODY;
                    end
                end
            end
            vdhp_pkg::PH_BODY: begin
                pay = (r_count < {1'b0, r_len});
                if (r_count != vdhp_pkg::COUNT_MAX) n_count = r_count + 14'd1;
            end
            default: ;
        endcase

        // Summary on the last byte.
        st = n_err;
        if (st == vdhp_pkg::ST_OK) begin
            if (n_phase != vdhp_pkg::PH_BODY) st = vdhp_pkg::ST_TRUNCATED;
            else if (n_count == {1'b0, n_len}) pos = 1'b0;
            else if (n_count == {1'b0, n_len} + vdhp_pkg::POS_BYTES) pos = 1'b1;
            else st = vdhp_pkg::ST_BAD_COUNT;
        end
        o_emit = i_take && (i_last || pay);
        o_res = '0;
        o_res.kind = i_last;
        o_res.out_byte = pay ? i_byte : 8'd0;
        o_res.byte_valid = pay;
        if (i_last) begin
            o_res.status = st;
            o_res.pkt_type = n_type;
            o_res.target = n_target;
            o_res.sender_session = n_sender;
            o_res.frame_sequence = n_seq;
            o_res.payload_length = n_len;
            o_res.terminator = n_term;
            o_res.has_position = (st == vdhp_pkg::ST_OK) && pos;
        end
    end

    // Datagram state; a summary returns it to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase <= vdhp_pkg::PH_FIRST; r_acc <= '0; r_left <= '0; r_inv <= 1'b0;
            r_type <= '0; r_target <= '0; r_sender <= '0; r_seq <= '0;
            r_len <= '0; r_term <= 1'b0; r_count <= '0; r_err <= vdhp_pkg::ST_OK;
        end else if (i_take) begin
            r_phase <= n_phase; r_acc <= n_acc; r_left <= n_left; r_inv <= n_inv;
            r_type <= n_type; r_target <= n_target; r_sender <= n_sender; r_seq <= n_seq;
            r_len <= n_len; r_term <= n_term; r_count <= n_count; r_err <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_left_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != 4'd0) |-> (r_phase == vdhp_pkg::PH_SENDER ||
        r_phase == vdhp_pkg::PH_SEQ || r_phase == vdhp_pkg::PH_LEN))
        else $error("varint byte count outside header");
    a_err_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != vdhp_pkg::ST_OK) |-> (r_phase == vdhp_pkg::PH_DRAIN))
        else $error("error recorded outside drain");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last) |=> (r_phase == vdhp_pkg::PH_FIRST))
        else $error("summary did not clear state");
`endif

endmodule

// ----- sv/vdhp_queue.sv -----
// Back part: a short result queue that parts the parser from the consumer.
module vdhp_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vdhp_pkg::t_result i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output vdhp_pkg::t_result o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    vdhp_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr] <= i_data;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + AW'(1);
            if (rd_en) r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_cnt == $past(r_cnt) + (AW+1)'(1)))
        else $error("queue count lost a transfer");
    a_ptr_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd)) else $error("empty queue pointers differ");
`endif

endmodule

// ----- sv/voice_datagram_header_parser_core.sv -----
// Top level of the voice datagram header parser: front parser and result queue.
//  channel | direction | handshake        | payload
//  input   | in        | push / full      | i_in_byte, i_end_of_datagram
//  result  | out       | empty / pop      | o_kind .. o_has_position
//  config  | in        | i_cfg_we         | i_cfg_index, i_cfg_data
// One byte is taken per cycle while full is low; the front parser is combinational
// over its state registers. A result is written into the queue at the edge that takes
// its byte and, if the queue was empty, is on the result ports from the next cycle.
// full is high while the queue holds DEPTH results; the input stalls with it, even
// when a pop happens in the same cycle.
// Reset is synchronous and returns the registers to their reset values.
module voice_datagram_header_parser_core #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_datagram,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic [2:0]  o_status,
    output logic [2:0]  o_pkt_type,
    output logic [4:0]  o_target,
    output logic [31:0] o_sender_session,
    output logic [63:0] o_frame_sequence,
    output logic [12:0] o_payload_length,
    output logic        o_terminator,
    output logic        o_has_position,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data
);

    logic              r_has_sender;
    logic [2:0]        r_max_type;
    logic              take, emit;
    vdhp_pkg::t_result res, q_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_sender <= 1'b0;
            r_max_type <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vdhp_pkg::CFG_HAS_SENDER: r_has_sender <= i_cfg_data[0];
                vdhp_pkg::CFG_MAX_TYPE:   r_max_type <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign take = push && !full;

    vdhp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_byte(i_in_byte),
        .i_last(i_end_of_datagram), .i_has_sender(r_has_sender),
        .i_max_type(r_max_type), .o_emit(emit), .o_res(res)
    );

    vdhp_queue #(.DEPTH(DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(emit), .i_data(res),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_data(q_out)
    );

    assign o_kind = q_out.kind;
    assign o_out_byte = q_out.out_byte;
    assign o_byte_valid = q_out.byte_valid;
    assign o_status = q_out.status;
    assign o_pkt_type = q_out.pkt_type;
    assign o_target = q_out.target;
    assign o_sender_session = q_out.sender_session;
    assign o_frame_sequence = q_out.frame_sequence;
    assign o_payload_length = q_out.payload_length;
    assign o_terminator = q_out.terminator;
    assign o_has_position = q_out.has_position;

endmodule
